[rtl/sfcd_pkg.sv]
// Shared types and constants for the strip/fan command decoder.
// Used by every module of the decoder and by its checker.
package sfcd_pkg;

  localparam int unsigned MaxGroups = 65535;

  localparam logic [1:0] CFG_STREAM_LEN   = 2'd0;
  localparam logic [1:0] CFG_VERTEX_LIMIT = 2'd1;
  localparam logic [1:0] CFG_NORMAL_LIMIT = 2'd2;

  localparam logic KIND_TRIANGLE = 1'b0;
  localparam logic KIND_FINISHED = 1'b1;

  typedef struct packed {
    logic [15:0] stream_word;
    logic        start_of_stream;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] vertex_a;
    logic [15:0] normal_a;
    logic [15:0] vertex_b;
    logic [15:0] normal_b;
    logic [15:0] vertex_c;
    logic [15:0] normal_c;
    logic        index_fault;
    logic [30:0] triangles_so_far;
    logic        last_of_run;
  } res_t;

  // Results caused by one accepted word, r0 first.
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic corner_bad(logic [31:0] c, logic [16:0] vlim,
                                      logic [16:0] nlim);
    return ({1'b0, c[31:16]} >= vlim) || ({1'b0, c[15:0]} >= nlim);
  endfunction

endpackage

[rtl/sfcd_decode.sv]
// Stream word decoder: configuration registers, decode state and triangle assembly.
// Depends on sfcd_pkg.
module sfcd_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [30:0]    cfg_wdata_i,
  input  logic           accept_i,
  input  sfcd_pkg::in_t  in_data_i,
  output sfcd_pkg::push_t push_o
);
  import sfcd_pkg::*;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_COUNT = 2'd1;
  localparam logic [1:0] MODE_VERTS = 2'd2;
  localparam logic [1:0] MODE_DONE  = 2'd3;

  localparam logic [30:0] TriMax = '1;

  logic [30:0] len_q;
  logic [16:0] vlim_q, nlim_q;

  logic [1:0]  mode_q, mode_e, mode_d;
  logic [1:0]  phase_q, phase_e, phase_d;
  logic [30:0] rem_q, rem_e, rem_d, rem_dec;
  logic [15:0] gvc_q, gvc_e, gvc_d;
  logic [15:0] vpos_q, vpos_e, vpos_d;
  logic        fan_q, fan_e, fan_d;
  logic [15:0] grp_q, grp_e, grp_d;
  logic [30:0] tri_q, tri_e, tri_d;
  logic [31:0] c0_q, c0_d, c1_q, c1_d, c2_q, c2_d;
  logic [15:0] pv_q, pv_d, pn_q, pn_d;

  logic [15:0] word;
  logic        neg;
  logic [16:0] mag;
  logic [31:0] cur, ca, cb;
  logic        tri_v, fin_v;
  res_t        tri_r, fin_r;

  assign word = in_data_i.stream_word;
  assign neg  = word[15];
  assign mag  = neg ? (17'h10000 - {1'b0, word}) : {1'b0, word};
  assign cur  = {pv_q, pn_q};

  always_comb begin
    mode_e  = mode_q;
    phase_e = phase_q;
    rem_e   = rem_q;
    gvc_e   = gvc_q;
    vpos_e  = vpos_q;
    fan_e   = fan_q;
    grp_e   = grp_q;
    tri_e   = tri_q;
    if (in_data_i.start_of_stream) begin
      mode_e  = MODE_COUNT;
      phase_e = '0;
      rem_e   = len_q;
      gvc_e   = '0;
      vpos_e  = '0;
      fan_e   = 1'b0;
      grp_e   = '0;
      tri_e   = '0;
    end

    mode_d  = mode_e;
    phase_d = phase_e;
    rem_d   = rem_e;
    gvc_d   = gvc_e;
    vpos_d  = vpos_e;
    fan_d   = fan_e;
    grp_d   = grp_e;
    tri_d   = tri_e;
    c0_d    = c0_q;
    c1_d    = c1_q;
    c2_d    = c2_q;
    pv_d    = pv_q;
    pn_d    = pn_q;
    tri_v   = 1'b0;
    fin_v   = 1'b0;
    ca      = c1_q;
    cb      = c2_q;
    rem_dec = rem_e - 31'd1;

    if (mode_e == MODE_COUNT || mode_e == MODE_VERTS) begin
      if (rem_e == '0) begin
        fin_v = 1'b1;
      end else begin
        rem_d = rem_dec;
        if (mode_e == MODE_COUNT) begin
          if (word == '0) begin
            fin_v = 1'b1;
          end else if (rem_dec < {12'd0, mag, 2'b00}) begin
            fin_v = 1'b1;
          end else begin
            fan_d   = neg;
            gvc_d   = mag[15:0];
            vpos_d  = '0;
            phase_d = '0;
            mode_d  = MODE_VERTS;
          end
        end else begin
          case (phase_e)
            2'd0: pv_d = word;
            2'd1: pn_d = word;
            2'd3: begin
              if (vpos_e == '0) c0_d = cur;
              if (fan_e) begin
                ca = c0_q;
                cb = c2_q;
              end else if (!vpos_e[0]) begin
                ca = c1_q;
                cb = c2_q;
              end else begin
                ca = c2_q;
                cb = c1_q;
              end
              if (vpos_e >= 16'd2) begin
                tri_v = 1'b1;
                if (tri_e != TriMax) tri_d = tri_e + 31'd1;
              end
              c1_d = c2_q;
              c2_d = cur;
              if ({1'b0, vpos_e} + 17'd1 >= {1'b0, gvc_e}) begin
                grp_d = grp_e + 16'd1;
                if ({16'd0, grp_d} >= MaxGroups || rem_dec == '0) begin
                  fin_v = 1'b1;
                end else begin
                  mode_d = MODE_COUNT;
                end
              end else begin
                vpos_d = vpos_e + 16'd1;
              end
            end
            default: ;
          endcase
          phase_d = phase_e + 2'd1;
        end
      end
    end
    if (fin_v) mode_d = MODE_DONE;
  end

  always_comb begin
    tri_r.result_kind      = KIND_TRIANGLE;
    tri_r.vertex_a         = ca[31:16];
    tri_r.normal_a         = ca[15:0];
    tri_r.vertex_b         = cb[31:16];
    tri_r.normal_b         = cb[15:0];
    tri_r.vertex_c         = cur[31:16];
    tri_r.normal_c         = cur[15:0];
    tri_r.index_fault      = corner_bad(ca, vlim_q, nlim_q) | corner_bad(cb, vlim_q, nlim_q)
                           | corner_bad(cur, vlim_q, nlim_q);
    tri_r.triangles_so_far = tri_d;
    tri_r.last_of_run      = !fin_v;

    fin_r                  = '0;
    fin_r.result_kind      = KIND_FINISHED;
    fin_r.triangles_so_far = tri_d;
    fin_r.last_of_run      = 1'b1;

    push_o.r0  = tri_v ? tri_r : fin_r;
    push_o.r1  = fin_r;
    push_o.num = accept_i ? ({1'b0, tri_v} + {1'b0, fin_v}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      vlim_q <= '0;
      nlim_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STREAM_LEN:   len_q  <= cfg_wdata_i;
        CFG_VERTEX_LIMIT: vlim_q <= cfg_wdata_i[16:0];
        CFG_NORMAL_LIMIT: nlim_q <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= '0;
      rem_q   <= '0;
      gvc_q   <= '0;
      vpos_q  <= '0;
      fan_q   <= 1'b0;
      grp_q   <= '0;
      tri_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      rem_q   <= rem_d;
      gvc_q   <= gvc_d;
      vpos_q  <= vpos_d;
      fan_q   <= fan_d;
      grp_q   <= grp_d;
      tri_q   <= tri_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      c0_q <= c0_d;
      c1_q <= c1_d;
      c2_q <= c2_d;
      pv_q <= pv_d;
      pn_q <= pn_d;
    end
  end

endmodule

[rtl/sfcd_out_queue.sv]
// Four-entry result queue: takes up to two results per cycle, delivers one unless the output is stalled.
// Depends on sfcd_pkg.
module sfcd_out_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sfcd_pkg::push_t push_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output sfcd_pkg::res_t  out_data_o,
  output logic            space_o
);
  import sfcd_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign space_o     = (cnt_q <= 3'd2);
  assign cnt_d       = cnt_q + {1'b0, push_i.num} - {2'b00, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.num;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.num == 2'd2) mem_q[wr_q + 2'd1] <= push_i.r1;
  end

endmodule

[rtl/strip_fan_command_decoder_core.sv]
// Top level of the strip/fan command decoder: decoder plus result queue.
// Depends on sfcd_pkg, sfcd_decode and sfcd_out_queue.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one 16-bit
//   stream word per transfer; start_of_stream restarts decoding on that word.
//   Output channel (out_valid_o / out_stall_i / out_data_o) delivers triangle
//   and stream-finished results in order, at most two per input word.
//   Configuration (cfg_we_i / cfg_idx_i / cfg_wdata_i) writes buffer length
//   and index limits; write only while the block is idle.
//   Results are written into the result queue when their word transfers.
//   Throughput: one word per cycle unless in_stall_o is raised; the four-entry
//   result queue raises in_stall_o when more than two results wait, so a word
//   that makes two results needs two output transfers.
//   Reset: decoder idle, queue empty, configuration registers zero; words without
//   start_of_stream are then consumed silently.
//   A stalled receiver holds the queue head; input stalls once more than two results wait.
module strip_fan_command_decoder_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sfcd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sfcd_pkg::res_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [30:0]    cfg_wdata_i
);
  import sfcd_pkg::*;

  push_t push;
  logic  space;
  logic  accept;

  assign in_stall_o = !space;
  assign accept     = in_valid_i && space;

  sfcd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .push_o     (push)
  );

  sfcd_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .space_o    (space)
  );

endmodule

[rtl/sfcd_checker.sv]
// Port-level checks for the strip/fan command decoder, bound to the top level.
// Depends on sfcd_pkg.
module sfcd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input sfcd_pkg::res_t out_data_o
);
  import sfcd_pkg::*;

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // finished always closes the run
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_FINISHED |-> out_data_o.last_of_run)
    else $error("finished result not last of run");

  a_fin_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_FINISHED |->
      out_data_o.vertex_a == '0 && out_data_o.vertex_c == '0 && !out_data_o.index_fault)
    else $error("finished result carries corner data");

  a_tri_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_TRIANGLE |->
      out_data_o.triangles_so_far != '0)
    else $error("triangle with zero count");

  // empty queue never stalls input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind strip_fan_command_decoder_core sfcd_checker u_sfcd_checker (.*);

[dv/tb_strip_fan_command_decoder_core.sv]
// Self-checking bench for strip_fan_command_decoder_core: drives command-stream words with
// random gaps and result stalls, predicts triangles and stream ends, and checks each field.
// Depends on sfcd_pkg and strip_fan_command_decoder_core.
module tb_strip_fan_command_decoder_core;
  import sfcd_pkg::*;

  localparam int StuckLimit = 2000;
  localparam logic [30:0] LenMax = 31'h7FFF_FFFF;
  localparam logic [16:0] LimMax = 17'h10000;

  localparam logic [1:0] SlotVertex = 2'd0;
  localparam logic [1:0] SlotNormal = 2'd1;
  localparam logic [1:0] SlotT      = 2'd3;

  typedef enum logic [1:0] {DEC_IDLE, DEC_COUNT, DEC_VERTS, DEC_DONE} dec_mode_e;
  typedef enum logic [1:0] {BY_PREDICTOR, NO_RESULT, FINISHED_EMPTY} row_check_e;

  typedef struct packed {
    logic        is_reg;
    logic [1:0]  reg_idx;
    logic [30:0] reg_val;
    logic        sos;
    logic [15:0] word;
    row_check_e  how;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  res_t        out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [30:0] cfg_wdata_i;

  strip_fan_command_decoder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // decoder state mirror
  logic [30:0] buf_len = '0;
  logic [16:0] vtx_lim = '0;
  logic [16:0] nrm_lim = '0;
  dec_mode_e   dec_mode = DEC_IDLE;
  logic [1:0]  word_phase = SlotVertex;
  logic [30:0] words_left = '0;
  logic [15:0] group_len = '0;
  logic [15:0] vtx_pos = '0;
  logic [15:0] groups_done = '0;
  logic        fan_grp = 1'b0;
  logic [31:0] corners [3];
  logic [15:0] held_vtx, held_nrm;
  logic [30:0] tri_count = '0;

  res_t fresh[$];
  res_t results_due[$];
  res_t got_res, want_res;

  bit steady = 1'b0;
  int live_words = 0;
  int sent_words = 0;
  int mismatches = 0;
  int results_seen = 0;
  int tris_seen = 0;
  int faults_seen = 0;
  int ends_seen = 0;

  plan_row_t plan [23] = '{
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'h1234, NO_RESULT},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b1, 16'h0005, FINISHED_EMPTY},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'hFFFF, NO_RESULT},
    '{1'b1, CFG_STREAM_LEN,   31'd13, 1'b0, 16'h0000, BY_PREDICTOR},
    '{1'b1, CFG_VERTEX_LIMIT, 31'd0,  1'b0, 16'h0000, BY_PREDICTOR},
    '{1'b1, CFG_NORMAL_LIMIT, 31'd0,  1'b0, 16'h0000, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b1, 16'h8000, FINISHED_EMPTY},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b1, 16'h0000, FINISHED_EMPTY},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b1, 16'hFFFD, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'hFFFF, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'hFFFF, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'h8000, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'h7FFF, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'h0000, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'h0000, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'h5555, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'hAAAA, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'h8001, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'h7FFE, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'hFFFF, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'h0000, BY_PREDICTOR},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b0, 16'h0003, NO_RESULT},
    '{1'b0, CFG_STREAM_LEN,   31'd0,  1'b1, 16'h0001, BY_PREDICTOR}
  };

  function automatic logic corner_out(logic [31:0] c);
    return ({1'b0, c[31:16]} >= vtx_lim) || ({1'b0, c[15:0]} >= nrm_lim);
  endfunction

  function automatic void emit(logic kind, logic [31:0] a, logic [31:0] b,
                               logic [31:0] c, logic fault);
    res_t r;
    r.result_kind      = kind;
    r.vertex_a         = a[31:16];
    r.normal_a         = a[15:0];
    r.vertex_b         = b[31:16];
    r.normal_b         = b[15:0];
    r.vertex_c         = c[31:16];
    r.normal_c         = c[15:0];
    r.index_fault      = fault;
    r.triangles_so_far = tri_count;
    r.last_of_run      = 1'b0;
    fresh.push_back(r);
  endfunction

  function automatic void end_stream();
    emit(KIND_FINISHED, '0, '0, '0, 1'b0);
    dec_mode = DEC_DONE;
  endfunction

  // Advances the mirror by one word; results land in fresh. Returns 1 if the word was decoded.
  function automatic bit decode_word(in_t item);
    logic [16:0] mag;
    logic [31:0] cur, a, b;
    fresh.delete();
    if (item.start_of_stream) begin
      dec_mode    = DEC_COUNT;
      words_left  = buf_len;
      groups_done = '0;
      tri_count   = '0;
      word_phase  = SlotVertex;
      vtx_pos     = '0;
      group_len   = '0;
      fan_grp     = 1'b0;
    end
    if (dec_mode != DEC_COUNT && dec_mode != DEC_VERTS) return 1'b0;
    if (words_left == 0) begin
      end_stream();
    end else begin
      words_left = words_left - 31'd1;
      if (dec_mode == DEC_COUNT) begin
        if (item.stream_word == 16'h0) begin
          end_stream();
        end else begin
          mag = item.stream_word[15] ? 17'h10000 - {1'b0, item.stream_word}
                                     : {1'b0, item.stream_word};
          if (longint'(words_left) < longint'(mag) * 4) begin
            end_stream();
          end else begin
            fan_grp    = item.stream_word[15];
            group_len  = mag[15:0];
            vtx_pos    = '0;
            word_phase = SlotVertex;
            dec_mode   = DEC_VERTS;
          end
        end
      end else begin
        case (word_phase)
          SlotVertex: held_vtx = item.stream_word;
          SlotNormal: held_nrm = item.stream_word;
          SlotT: begin
            cur = {held_vtx, held_nrm};
            if (vtx_pos == 0) corners[0] = cur;
            if (vtx_pos >= 2) begin
              if (fan_grp) begin
                a = corners[0];
                b = corners[2];
              end else if (!vtx_pos[0]) begin
                a = corners[1];
                b = corners[2];
              end else begin
                a = corners[2];
                b = corners[1];
              end
              if (tri_count != LenMax) tri_count = tri_count + 31'd1;
              emit(KIND_TRIANGLE, a, b, cur, corner_out(a) || corner_out(b) || corner_out(cur));
            end
            corners[1] = corners[2];
            corners[2] = cur;
            if (32'(vtx_pos) + 1 >= 32'(group_len)) begin
              groups_done = groups_done + 16'd1;
              if (groups_done >= MaxGroups || words_left == 0) end_stream();
              else dec_mode = DEC_COUNT;
            end else begin
              vtx_pos = vtx_pos + 16'd1;
            end
          end
          default: ;
        endcase
        word_phase = word_phase + 2'd1;
      end
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last_of_run = 1'b1;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
    mismatches++;
    $display("%0t: %s got %0h expected %0h", $time, what, got_v, want_v);
  endtask

  task automatic send_item(logic sos, logic [15:0] word, row_check_e how = BY_PREDICTOR);
    in_t  item;
    res_t lone;
    int   gap;
    item.stream_word     = word;
    item.start_of_stream = sos;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sent_words++;
    if (decode_word(item)) live_words++;
    lone = '0;
    case (how)
      BY_PREDICTOR: foreach (fresh[i]) results_due.push_back(fresh[i]);
      FINISHED_EMPTY: begin
        lone.result_kind = KIND_FINISHED;
        lone.last_of_run = 1'b1;
        results_due.push_back(lone);
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_STREAM_LEN:   buf_len = val;
      CFG_VERTEX_LIMIT: vtx_lim = val[16:0];
      CFG_NORMAL_LIMIT: nrm_lim = val[16:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(logic [30:0] len, logic [16:0] vl, logic [16:0] nl);
    drain();
    set_reg(CFG_STREAM_LEN, len);
    set_reg(CFG_VERTEX_LIMIT, {14'd0, vl});
    set_reg(CFG_NORMAL_LIMIT, {14'd0, nl});
  endtask

  // Indices mostly from zero up to the table limit, some right at it, some fully random, so faults come and go.
  function automatic logic [15:0] pick_index(logic [16:0] lim);
    int hi;
    hi = (lim > 17'd65535) ? 65535 : int'(lim);
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(hi > 3 ? hi - 3 : 0, hi));
      default: return 16'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic feed_stream();
    int          nv;
    logic [15:0] cnt;
    logic        first;
    first = 1'b1;
    repeat ($urandom_range(1, 6)) begin
      nv  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      cnt = $urandom_range(0, 1) ? 16'(-nv) : 16'(nv);
      if ($urandom_range(0, 15) == 0) cnt = 16'($urandom);
      send_item(first, cnt);
      first = 1'b0;
      for (int v = 0; v < nv; v++) begin
        send_item(1'b0, pick_index(vtx_lim));
        if ($urandom_range(0, 63) == 0) return;
        send_item(1'b0, pick_index(nrm_lim));
        send_item(1'b0, 16'($urandom));
        send_item(1'b0, 16'($urandom));
      end
      if ($urandom_range(0, 11) == 0) return;
    end
    if ($urandom_range(0, 1)) send_item(1'b0, 16'h0000);
  endtask

  // result side
  initial begin
    int hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_res = out_data_o;
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing expected, kind", got_res.result_kind, '0);
      end else begin
        want_res = results_due.pop_front();
        results_seen++;
        if (want_res.result_kind == KIND_TRIANGLE) tris_seen++;
        else ends_seen++;
        if (want_res.index_fault) faults_seen++;
        if (got_res.result_kind !== want_res.result_kind)
          report_mismatch("result_kind", got_res.result_kind, want_res.result_kind);
        if (got_res.vertex_a !== want_res.vertex_a)
          report_mismatch("vertex_a", got_res.vertex_a, want_res.vertex_a);
        if (got_res.normal_a !== want_res.normal_a)
          report_mismatch("normal_a", got_res.normal_a, want_res.normal_a);
        if (got_res.vertex_b !== want_res.vertex_b)
          report_mismatch("vertex_b", got_res.vertex_b, want_res.vertex_b);
        if (got_res.normal_b !== want_res.normal_b)
          report_mismatch("normal_b", got_res.normal_b, want_res.normal_b);
        if (got_res.vertex_c !== want_res.vertex_c)
          report_mismatch("vertex_c", got_res.vertex_c, want_res.vertex_c);
        if (got_res.normal_c !== want_res.normal_c)
          report_mismatch("normal_c", got_res.normal_c, want_res.normal_c);
        if (got_res.index_fault !== want_res.index_fault)
          report_mismatch("index_fault", got_res.index_fault, want_res.index_fault);
        if (got_res.triangles_so_far !== want_res.triangles_so_far)
          report_mismatch("triangles_so_far", got_res.triangles_so_far,
                          want_res.triangles_so_far);
        if (got_res.last_of_run !== want_res.last_of_run)
          report_mismatch("last_of_run", got_res.last_of_run, want_res.last_of_run);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StuckLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no transfer in %0d cycles", StuckLimit);
    $display("strip_fan_command_decoder_core: mismatch");
    $finish;
  end

  initial begin
    int phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_STREAM_LEN;
    cfg_wdata_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain();
        set_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].sos, plan[i].word, plan[i].how);
      end
    end

    phase = 0;
    while (sent_words < 1000) begin
      case (phase % 5)
        0: reconfigure(LenMax, LimMax, LimMax);
        1: reconfigure(31'($urandom_range(0, 60)), 17'($urandom_range(0, 65536)),
                       17'($urandom_range(0, 65536)));
        2: reconfigure(31'($urandom_range(100, 400)), 17'($urandom_range(1, 24)),
                       17'($urandom_range(1, 24)));
        3: reconfigure(LenMax, '0, LimMax);
        default: reconfigure(31'($urandom_range(13, 120)), 17'($urandom_range(0, 8)),
                             17'($urandom_range(65530, 65536)));
      endcase
      steady = (phase % 4 == 2);
      repeat ($urandom_range(3, 6)) begin
        if (sent_words >= 1000) break;
        feed_stream();
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_item($urandom_range(0, 7) == 0, 16'($urandom));
      end
      phase++;
    end
    steady = 1'b0;
    drain();

    $display("sent %0d stream words (%0d decoded) over %0d config phases",
             sent_words, live_words, phase);
    $display("checked %0d results: %0d triangles (%0d with bad indices), %0d stream ends",
             results_seen, tris_seen, faults_seen, ends_seen);
    if (mismatches == 0) $display("strip_fan_command_decoder_core: match");
    else $display("strip_fan_command_decoder_core: mismatch");
    $finish;
  end

endmodule
